[sv/edh_pkg.sv]
// Package for the error diffusion halftoning block.
// Holds the shared widths, register codes, reset values and the kernel structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edh_pkg;

   // Payload and accumulator widths.
   localparam int PIX_W      = 8;
   localparam int ACC_W      = 11;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int ROW_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd2;

   // Register reset values and limits.
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd512;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 13'd512;
   localparam logic [PIX_W-1:0]    THRESHOLD_RESET = 8'd128;
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT    = 13'd4096;

   // Output levels.
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

   typedef logic signed [ACC_W-1:0] acc_type;

   // Operands of the diffusion kernel for one pixel.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      acc_type          right_carry;
      acc_type          above;
      acc_type          below_left_part;
      acc_type          below_part;
      logic [PIX_W-1:0] threshold;
   } kern_in_type;

   // Results of the diffusion kernel for one pixel.
   typedef struct packed {
      logic    white;
      acc_type right_share;
      acc_type left_sum;
      acc_type below_sum;
      acc_type below_right_share;
   } kern_out_type;

endpackage

`default_nettype wire

[sv/edh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module edh_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/edh_kernel.sv]
// Per-pixel diffusion arithmetic: correction, threshold and the four error shares.
// Uses edh_pkg for the operand and result structs.
`timescale 1ns / 1ps
`default_nettype none

module edh_kernel (
   input  edh_pkg::kern_in_type  kin,
   output edh_pkg::kern_out_type kout
);
   import edh_pkg::*;

   // Saturate a 13-bit signed sum to the 11-bit accumulator range.
   function automatic acc_type sat_acc(input logic signed [12:0] v);
      acc_type r;
      if (v > 13'sd1023) begin
         r = 11'sd1023;
      end else if (v < -13'sd1024) begin
         r = -11'sd1024;
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

   // Divide a signed product by 16, truncating toward zero.
   function automatic acc_type div16(input logic signed [14:0] p);
      logic signed [14:0] q;
      q = p + (p[14] ? 15'sd15 : 15'sd0);
      q = q >>> 4;
      return q[10:0];
   endfunction

   logic signed [12:0] sum;
   acc_type            corrected;
   logic               white;
   logic signed [11:0] err;
   logic signed [14:0] err_ext;
   acc_type            s7;
   acc_type            s5;
   acc_type            s3;
   acc_type            s1;

   // Corrected value and threshold decision.
   always_comb begin
      sum = $signed({5'b0, kin.pixel})
          + $signed({{2{kin.right_carry[ACC_W-1]}}, kin.right_carry})
          + $signed({{2{kin.above[ACC_W-1]}}, kin.above});
      corrected = sat_acc(sum);
      white     = corrected >= $signed({3'b0, kin.threshold});
      err       = $signed({corrected[ACC_W-1], corrected})
                - (white ? 12'sd255 : 12'sd0);
   end

   // Floyd-Steinberg shares of the error.
   always_comb begin
      err_ext = $signed({{3{err[11]}}, err});
      s7 = div16(err_ext * 15'sd7);
      s5 = div16(err_ext * 15'sd5);
      s3 = div16(err_ext * 15'sd3);
      s1 = div16(err_ext);
   end

   // Merge the shares into the partial sums of the row below.
   always_comb begin
      kout.white             = white;
      kout.right_share       = s7;
      kout.left_sum          = sat_acc(
         $signed({{2{kin.below_left_part[ACC_W-1]}}, kin.below_left_part})
         + $signed({{2{s3[ACC_W-1]}}, s3}));
      kout.below_sum         = sat_acc(
         $signed({{2{kin.below_part[ACC_W-1]}}, kin.below_part})
         + $signed({{2{s5[ACC_W-1]}}, s5}));
      kout.below_right_share = s1;
   end

endmodule

`default_nettype wire

[sv/error_diffusion_halftone.sv]
// Floyd-Steinberg error diffusion halftoner. The input register loads when a request
// is accepted and the result register when the pixel leaves the input stage, which a
// held result can delay. Throughput: one pixel per clock while the result channel does
// not stall; the row buffer reads once and writes once a cycle. Reset (synchronous):
// clears counters, carries, valids and registers to defaults; the row buffer is not
// cleared since row 0 never uses it. Depends on edh_pkg, edh_ram and edh_kernel.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_halftone #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Configuration port.
   input  wire logic                           csr_wr_en,
   input  wire logic [edh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [edh_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Request channel.
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [edh_pkg::PIX_W-1:0]      req_gray_pixel,
   // Result channel.
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [edh_pkg::PIX_W-1:0]      rsp_binary_pixel,
   output logic                                rsp_end_of_row,
   output logic                                rsp_end_of_frame
);
   import edh_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

   // Configuration registers.
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [PIX_W-1:0]    thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thr_ff    <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_THRESHOLD:    thr_ff    <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake control.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic fire;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   // Clamped frame size and end-of-row / end-of-frame detection.
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CMPW-1:0]     w_ext, w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic                last_col, last_row;

   always_comb begin
      w_ext = CMPW'(width_ff);
      if (w_ext == '0) begin
         w_eff = CMPW'(1);
      end else if (w_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
      last_col = (CMPW'(col_ff) + CMPW'(1)) >= w_eff;
      last_row = ({1'b0, row_ff} + HEIGHT_W'(1)) >= h_eff;
      col_in   = last_col ? '0 : col_ff + CW'(1);
      row_in   = last_col ? (last_row ? '0 : row_ff + ROW_W'(1)) : row_ff;
   end

   // Raster position counters advance on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Row buffer write port: the below-left write of the current pixel, or the
   // deferred below write left by the last pixel of a row.
   logic          comp_wr;
   logic          buf_wr_en;
   logic [CW-1:0] buf_wr_addr;
   acc_type       buf_wr_data;
   acc_type       buf_rd_data;
   logic          pend_valid_ff, pend_valid_in;
   logic [CW-1:0] pend_addr_ff;
   acc_type       pend_data_ff;
   logic          pend_hit;

   // Input stage registers.
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_first_row_ff;
   logic             s1_last_col_ff;
   logic             s1_last_row_ff;
   logic             s1_byp_valid_ff, s1_byp_valid_in;
   acc_type          s1_byp_data_ff, s1_byp_data_in;

   // Diffusion state.
   acc_type rc_ff, rc_in;
   acc_type blp_ff, blp_in;
   acc_type bp_ff, bp_in;

   kern_in_type  kin;
   kern_out_type kout;

   edh_kernel u_kernel (
      .kin  (kin),
      .kout (kout)
   );

   // With one-pixel rows the deferred write lands on the waiting pixel's column in
   // the very cycle that pixel may leave, so it is forwarded straight away.
   assign pend_hit = pend_valid_ff && (pend_addr_ff == s1_col_ff);

   always_comb begin
      kin.pixel           = s1_pix_ff;
      kin.right_carry     = rc_ff;
      kin.above           = s1_first_row_ff ? '0
                          : (pend_hit ? pend_data_ff
                          : (s1_byp_valid_ff ? s1_byp_data_ff : buf_rd_data));
      kin.below_left_part = blp_ff;
      kin.below_part      = bp_ff;
      kin.threshold       = thr_ff;
   end

   assign comp_wr = fire && !s1_last_row_ff && (s1_col_ff != '0);

   always_comb begin
      if (pend_valid_ff) begin
         buf_wr_en   = 1'b1;
         buf_wr_addr = pend_addr_ff;
         buf_wr_data = pend_data_ff;
      end else begin
         buf_wr_en   = comp_wr;
         buf_wr_addr = s1_col_ff - CW'(1);
         buf_wr_data = kout.left_sum;
      end
   end

   edh_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_buf (
      .clock      (clock),
      .wr_en      (buf_wr_en),
      .wr_addr    (buf_wr_addr),
      .wr_data    (buf_wr_data),
      .rd_en      (accept),
      .rd_addr    (col_ff),
      .rd_data_ff (buf_rd_data)
   );

   // Forward a row buffer write that lands on the column of the waiting pixel
   // after its read was issued.
   always_comb begin
      s1_byp_valid_in = s1_byp_valid_ff;
      s1_byp_data_in  = s1_byp_data_ff;
      if (accept) begin
         s1_byp_valid_in = buf_wr_en && (buf_wr_addr == col_ff);
         s1_byp_data_in  = buf_wr_data;
      end else if (buf_wr_en && (buf_wr_addr == s1_col_ff)) begin
         s1_byp_valid_in = 1'b1;
         s1_byp_data_in  = buf_wr_data;
      end
   end

   // Input stage.
   assign s1_valid_in = accept || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s1_byp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s1_byp_valid_ff <= s1_byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byp_data_ff <= s1_byp_data_in;
      if (accept) begin
         s1_pix_ff       <= req_gray_pixel;
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_last_col_ff  <= last_col;
         s1_last_row_ff  <= last_row;
      end
   end

   // Next values of the carries and of the deferred write.
   always_comb begin
      rc_in         = s1_last_col_ff ? '0 : kout.right_share;
      pend_valid_in = fire && !s1_last_row_ff && s1_last_col_ff;
      if (s1_last_row_ff || s1_last_col_ff) begin
         blp_in = '0;
         bp_in  = '0;
      end else begin
         blp_in = kout.below_sum;
         bp_in  = kout.below_right_share;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff         <= '0;
         blp_ff        <= '0;
         bp_ff         <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (fire) begin
            rc_ff  <= rc_in;
            blp_ff <= blp_in;
            bp_ff  <= bp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_addr_ff <= s1_col_ff;
         pend_data_ff <= kout.below_sum;
      end
   end

   // Result register.
   logic [PIX_W-1:0] rsp_pix_ff;
   logic             rsp_eor_ff;
   logic             rsp_eof_ff;

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pix_ff <= kout.white ? PIX_WHITE : PIX_BLACK;
         rsp_eor_ff <= s1_last_col_ff;
         rsp_eof_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binary_pixel = rsp_pix_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // The deferred write never meets a below-left write in the same cycle.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(pend_valid_ff && comp_wr))
      else $error("row buffer write clash");

   // A held result is never overwritten by a new one.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> (req_stall && !fire))
      else $error("result overwritten while stalled");

   // The last pixel of a frame is also the last of its row.
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_end_of_row)
      else $error("end of frame without end of row");

   // A deferred write follows only a last-column pixel leaving the input stage.
   a_pend_origin: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(fire && s1_last_col_ff))
      else $error("deferred write without last column");

endmodule

`default_nettype wire

[tb/error_diffusion_halftone_tb.sv]
// Self-checking testbench for the error diffusion halftoner (error_diffusion_halftone).
// A directed table, random frames under three idling patterns, clamp runs; all scored
// against an internal Floyd-Steinberg predictor. Depends on edh_pkg and the block.
`timescale 1ns / 1ps

module error_diffusion_halftone_tb;
   import edh_pkg::*;

   localparam int MAX_COLS       = 1024;
   localparam int ACC_HI         = 1023;
   localparam int ACC_LO         = -1024;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_TARGET  = 150;
   localparam int CLAMP_PIXELS   = 40;

   typedef struct packed {
      logic [PIX_W-1:0] binary_pixel;
      logic             end_of_row;
      logic             end_of_frame;
   } halftone_out_type;

   typedef enum logic {STEP_PIXEL, STEP_CSR} step_kind_type;

   // One row of the directed table: a pixel request or a register write.
   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_IDX_W-1:0]  sel;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      halftone_out_type      want;
   } directed_step_type;

   localparam int DIRECTED_ROWS = 31;
   localparam directed_step_type DIRECTED_STEPS [DIRECTED_ROWS] = '{
      // Reset settings: width 512, height 512, threshold 128.
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd0,    1'b1, '{PIX_BLACK, 1'b0, 1'b0}},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd255,  1'b1, '{PIX_WHITE, 1'b0, 1'b0}},
      // Shrink the width mid-row: column 2 is now past the end of the row.
      '{STEP_CSR,   CSR_IMAGE_WIDTH,  13'd2,    1'b0, '0},
      '{STEP_CSR,   CSR_IMAGE_HEIGHT, 13'd2,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd128,  1'b1, '{PIX_WHITE, 1'b1, 1'b0}},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd100,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd200,  1'b0, '0},
      // Threshold zero: the first pixel of a frame is always white.
      '{STEP_CSR,   CSR_THRESHOLD,    13'd0,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd0,    1'b1, '{PIX_WHITE, 1'b0, 1'b0}},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd0,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd37,   1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd255,  1'b0, '0},
      // Zero width and height act as one: every pixel is a frame of its own.
      '{STEP_CSR,   CSR_THRESHOLD,    13'd255,  1'b0, '0},
      '{STEP_CSR,   CSR_IMAGE_WIDTH,  13'd0,    1'b0, '0},
      '{STEP_CSR,   CSR_IMAGE_HEIGHT, 13'd0,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd255,  1'b1, '{PIX_WHITE, 1'b1, 1'b1}},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd254,  1'b1, '{PIX_BLACK, 1'b1, 1'b1}},
      '{STEP_CSR,   CSR_THRESHOLD,    13'd128,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd127,  1'b1, '{PIX_BLACK, 1'b1, 1'b1}},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd128,  1'b1, '{PIX_WHITE, 1'b1, 1'b1}},
      // A full 3x3 frame exercises every share of the kernel.
      '{STEP_CSR,   CSR_IMAGE_WIDTH,  13'd3,    1'b0, '0},
      '{STEP_CSR,   CSR_IMAGE_HEIGHT, 13'd3,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd0,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd255,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd64,   1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd192,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd1,    1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd254,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd128,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd127,  1'b0, '0},
      '{STEP_PIXEL, CSR_IMAGE_WIDTH,  13'd255,  1'b0, '0}
   };

   // Block ports; the inputs are driven to known values from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_gray_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_binary_pixel;
   logic                  rsp_end_of_row;
   logic                  rsp_end_of_frame;

   // Predictor state and its copy of the registers.
   acc_type          row_err_mem [MAX_COLS];
   acc_type          carry_right;
   acc_type          part_below_left;
   acc_type          part_below;
   int               col_at;
   int               row_at;
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;
   logic [PIX_W-1:0]    cfg_threshold;

   halftone_out_type pending_pixels [$];
   int            mismatch_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;
   int            quiet_cycles = 0;

   error_diffusion_halftone #(
      .MAX_WIDTH(MAX_COLS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gray_pixel  (req_gray_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_binary_pixel(rsp_binary_pixel),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Saturate to the signed 11-bit accumulator range.
   function automatic acc_type clamp_acc(input int v);
      if (v > ACC_HI) return acc_type'(ACC_HI);
      if (v < ACC_LO) return acc_type'(ACC_LO);
      return acc_type'(v);
   endfunction

   // Share of the error for a weight in sixteenths, truncated toward zero.
   function automatic int weighted(input int wt, input int err);
      return (wt * err) / 16;
   endfunction

   function automatic int active_width();
      int w;
      w = int'(cfg_width);
      if (w < 1) w = 1;
      if (w > MAX_COLS) w = MAX_COLS;
      return w;
   endfunction

   function automatic int active_height();
      int h;
      h = int'(cfg_height);
      if (h < 1) h = 1;
      if (h > int'(HEIGHT_LIMIT)) h = int'(HEIGHT_LIMIT);
      return h;
   endfunction

   // Halftone one pixel and advance the predictor's position and error state.
   function automatic halftone_out_type halftone_pixel(input logic [PIX_W-1:0] gray);
      int               pix, rc, above, bl, bp, thr, corrected, level, err;
      bit               last_col, last_row;
      acc_type          below_new;
      halftone_out_type res;
      last_col = (col_at + 1 >= active_width());
      last_row = (row_at + 1 >= active_height());
      pix = int'(gray);
      rc = carry_right;
      bl = part_below_left;
      bp = part_below;
      thr = int'(cfg_threshold);
      above = 0;
      if (row_at > 0) above = row_err_mem[col_at];
      corrected = clamp_acc(pix + rc + above);
      level = (corrected >= thr) ? 255 : 0;
      err = corrected - level;

      carry_right = last_col ? acc_type'(0) : clamp_acc(weighted(7, err));

      // Error for the row below; nothing goes down from the last row.
      if (!last_row) begin
         if (col_at > 0) row_err_mem[col_at - 1] = clamp_acc(bl + weighted(3, err));
         below_new = clamp_acc(bp + weighted(5, err));
         if (last_col) begin
            row_err_mem[col_at] = below_new;
            part_below_left = '0;
            part_below = '0;
         end else begin
            part_below_left = below_new;
            part_below = clamp_acc(weighted(1, err));
         end
      end else begin
         part_below_left = '0;
         part_below = '0;
      end

      res.binary_pixel = (level != 0) ? PIX_WHITE : PIX_BLACK;
      res.end_of_row = last_col;
      res.end_of_frame = last_col && last_row;
      if (last_col) begin
         col_at = 0;
         row_at = last_row ? 0 : row_at + 1;
      end else begin
         col_at = col_at + 1;
      end
      return res;
   endfunction

   // Register write; the predictor's copy follows at once since the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] sel, input int unsigned data);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         CSR_IMAGE_WIDTH:  cfg_width = data[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
         CSR_THRESHOLD:    cfg_threshold = data[PIX_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Stop offering requests until every expected result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   // Offer one request, with random idle cycles ahead of it, and hold it until taken.
   task automatic push_pixel(input logic [PIX_W-1:0] gray, input bit typed,
                             input halftone_out_type typed_res,
                             output halftone_out_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_gray_pixel <= gray;
      do @(posedge clock); while (req_stall !== 1'b0);
      res = halftone_pixel(gray);
      pending_pixels.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   // Send pixels until the predictor marks the end of the frame. Now and then the
   // block is drained and a register is changed mid-frame: the threshold freely,
   // the width and height only downward so that no unwritten row entry is read.
   task automatic send_frame(inout int sent);
      int               style, base, n;
      logic [PIX_W-1:0] gray;
      halftone_out_type res;
      style = $urandom_range(3);
      base = $urandom_range(255);
      n = 0;
      do begin
         if (n > 0 && $urandom_range(149) == 0) begin
            wait_for_results();
            case ($urandom_range(2))
               0: write_csr(CSR_THRESHOLD, $urandom_range(255));
               1: write_csr(CSR_IMAGE_HEIGHT, $urandom_range(active_height()));
               default: write_csr(CSR_IMAGE_WIDTH, $urandom_range(active_width()));
            endcase
         end
         case (style)
            0: gray = PIX_W'($urandom_range(255));
            1: gray = ($urandom_range(1) == 1) ? PIX_WHITE : PIX_BLACK;
            2: gray = PIX_W'(base + int'($urandom_range(4)) - 2);
            default: gray = PIX_W'(base + n * 3);
         endcase
         push_pixel(gray, 1'b0, '0, res);
         n++;
      end while (!res.end_of_frame);
      sent += n;
   endtask

   // Random frames, each with a fresh random setting of some registers.
   task automatic run_random_frames(input int target);
      int sent, pick;
      sent = 0;
      while (sent < target) begin
         wait_for_results();
         if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            if (pick < 70) write_csr(CSR_IMAGE_WIDTH, $urandom_range(12, 2));
            else if (pick < 85) write_csr(CSR_IMAGE_WIDTH, $urandom_range(64, 13));
            else if (pick < 93) write_csr(CSR_IMAGE_WIDTH, 1);
            else write_csr(CSR_IMAGE_WIDTH, 0);
         end
         if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            if (pick < 80) write_csr(CSR_IMAGE_HEIGHT, $urandom_range(5, 1));
            else if (pick < 90) write_csr(CSR_IMAGE_HEIGHT, $urandom_range(12, 6));
            else write_csr(CSR_IMAGE_HEIGHT, 0);
         end
         if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            if (pick < 20) write_csr(CSR_THRESHOLD, 0);
            else if (pick < 40) write_csr(CSR_THRESHOLD, 255);
            else write_csr(CSR_THRESHOLD, $urandom_range(255));
         end
         send_frame(sent);
      end
   endtask

   // Receiver stall: random, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Score each accepted result against the oldest expectation.
   always @(posedge clock) begin : score_results
      halftone_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_pixels.size() == 0) begin
            $error("binary_pixel: expected no result, actual %0d", rsp_binary_pixel);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_binary_pixel !== want.binary_pixel) begin
               $error("binary_pixel: expected %0d, actual %0d",
                      want.binary_pixel, rsp_binary_pixel);
               mismatch_count++;
            end
            if (rsp_end_of_row !== want.end_of_row) begin
               $error("end_of_row: expected %0d, actual %0d",
                      want.end_of_row, rsp_end_of_row);
               mismatch_count++;
            end
            if (rsp_end_of_frame !== want.end_of_frame) begin
               $error("end_of_frame: expected %0d, actual %0d",
                      want.end_of_frame, rsp_end_of_frame);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles in a row with no request and no result taken.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      halftone_out_type res;
      int               sent;

      // Predictor reset state matches the block after reset.
      for (int i = 0; i < MAX_COLS; i++) row_err_mem[i] = '0;
      carry_right = '0;
      part_below_left = '0;
      part_below = '0;
      col_at = 0;
      row_at = 0;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_threshold = THRESHOLD_RESET;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, sender idling lightly and receiver heavily.
      send_idle_pct = 28;
      recv_stall_pct = 77;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED_STEPS[i].kind == STEP_CSR) begin
            wait_for_results();
            write_csr(DIRECTED_STEPS[i].sel, DIRECTED_STEPS[i].data);
         end else begin
            push_pixel(DIRECTED_STEPS[i].data[PIX_W-1:0], DIRECTED_STEPS[i].typed,
                       DIRECTED_STEPS[i].want, res);
         end
      end
      run_random_frames(RANDOM_TARGET);

      // Sender idles heavily, receiver lightly.
      send_idle_pct = 77;
      recv_stall_pct = 28;
      run_random_frames(RANDOM_TARGET);

      // No idling; first a long receiver hold-off while requests keep coming.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_for_results();
      write_csr(CSR_IMAGE_WIDTH, 16);
      write_csr(CSR_IMAGE_HEIGHT, 4);
      hold_requests = hold_requests + 1;
      sent = 0;
      send_frame(sent);
      run_random_frames(RANDOM_TARGET);

      // Width above the limit acts as the full row buffer, not as its low bits:
      // no row ends early; the row is then cut short by shrinking the width.
      wait_for_results();
      write_csr(CSR_IMAGE_WIDTH, 1025);
      write_csr(CSR_IMAGE_HEIGHT, 2);
      for (int i = 0; i < CLAMP_PIXELS; i++) begin
         push_pixel(PIX_W'($urandom_range(255)), 1'b0, '0, res);
      end
      wait_for_results();
      write_csr(CSR_IMAGE_WIDTH, 1);
      send_frame(sent);

      // Height above the limit clamps as well: one-pixel rows keep going until the
      // height is lowered, which makes the current row the last.
      wait_for_results();
      write_csr(CSR_IMAGE_WIDTH, 0);
      write_csr(CSR_IMAGE_HEIGHT, 4097);
      for (int i = 0; i < CLAMP_PIXELS; i++) begin
         push_pixel(PIX_W'($urandom_range(255)), 1'b0, '0, res);
      end
      wait_for_results();
      write_csr(CSR_IMAGE_HEIGHT, 0);
      send_frame(sent);

      wait_for_results();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
